>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the checker modules
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ihex_pkg.sv
// ---------------------------------------------------------------------------
// ihex_pkg
// shared types, codes and helpers of the intel hex record decoder
// ---------------------------------------------------------------------------
package ihex_pkg;

    localparam int IHEX_LINE_LENGTH_LIMIT = 1023;
    localparam int MAX_FLASH_WORDS        = 131072;

    localparam int FWC_W   = 18;
    localparam int ADDR_W  = 18;
    localparam int CODE_W  = 4;
    localparam int KIND_W  = 2;

    localparam logic [FWC_W-1:0] FWC_RESET = 18'd16384;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    // error codes
    localparam logic [CODE_W-1:0] ERR_AFTER_EOF = 4'd0;
    localparam logic [CODE_W-1:0] ERR_NO_COLON  = 4'd1;
    localparam logic [CODE_W-1:0] ERR_LENGTH    = 4'd2;
    localparam logic [CODE_W-1:0] ERR_DIGIT     = 4'd3;
    localparam logic [CODE_W-1:0] ERR_COUNT     = 4'd4;
    localparam logic [CODE_W-1:0] ERR_CHECKSUM  = 4'd5;
    localparam logic [CODE_W-1:0] ERR_CAPACITY  = 4'd6;
    localparam logic [CODE_W-1:0] ERR_EOF_REC   = 4'd7;
    localparam logic [CODE_W-1:0] ERR_EXT_REC   = 4'd8;
    localparam logic [CODE_W-1:0] ERR_TYPE      = 4'd9;
    localparam logic [CODE_W-1:0] ERR_NO_EOF    = 4'd10;

    // record types
    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;
    localparam logic [7:0] REC_EXT  = 8'h04;

    // characters
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_COLON = 8'h3a;

    // input actions
    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_END  = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] character;
    } ihex_item_t;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] byte_address;
        logic [7:0]        data_byte;
        logic [CODE_W-1:0] error_code;
    } ihex_result_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c inside {8'd9, 8'd11, 8'd12, 8'd13, 8'd32});
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            t = c - 8'h30;
            return {1'b1, t[3:0]};
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            t = c - 8'h57;
            return {1'b1, t[3:0]};
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            t = c - 8'h37;
            return {1'b1, t[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

>>> rtl/ihex_in_stage.sv
// ---------------------------------------------------------------------------
// ihex_in_stage
// input register holding one accepted item until the decoder takes it
// ---------------------------------------------------------------------------
module ihex_in_stage
    import ihex_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  ihex_item_t in_item,
    input  logic       take,
    output logic       held_valid,
    output ihex_item_t held_item
);

    logic       valid_reg;
    ihex_item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

>>> rtl/ihex_core.sv
// ---------------------------------------------------------------------------
// ihex_core
// line and record state, per-character decode and end-of-line checks
// ---------------------------------------------------------------------------
module ihex_core
    import ihex_pkg::*;
#(
    parameter int LINE_LENGTH_LIMIT = IHEX_LINE_LENGTH_LIMIT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [FWC_W-1:0] cfg_wr_data,
    input  logic             fire,
    input  ihex_item_t       item,
    output ihex_result_t     result
);

    localparam int LW = $clog2(LINE_LENGTH_LIMIT + 1);
    localparam int BW = LW - 1;
    localparam logic [LW-1:0] LIM = LW'(LINE_LENGTH_LIMIT);
    localparam logic [32:0] MAX_W = 33'(MAX_FLASH_WORDS);

    logic [FWC_W-1:0] fwc_reg;
    logic             eof_reg, eof_next;
    logic [15:0]      upper_reg, upper_next;
    logic             halted_reg, halted_next;
    logic             in_line_reg, in_line_next;
    logic [LW-1:0]    len_reg, len_next;
    logic [LW-1:0]    psc_reg, psc_next;
    logic [LW-1:0]    fbp_reg, fbp_next;
    logic             bad_reg, bad_next;
    logic [3:0]       hn_reg, hn_next;
    logic [7:0]       cnt_reg, cnt_next;
    logic [15:0]      off_reg, off_next;
    logic [7:0]       rkind_reg, rkind_next;
    logic [7:0]       sum_reg, sum_next;
    logic [15:0]      pb_reg, pb_next;

    // end-of-line check
    logic             el_err;
    logic [CODE_W-1:0] el_code;
    logic             el_eof;
    logic             el_base;
    logic [LW-1:0]    exp_len;
    logic [32:0]      end_addr;
    logic [32:0]      words;

    // character path
    logic             ws;
    logic [4:0]       hd;
    logic [LW:0]      len_sum;
    logic [LW-1:0]    len_c;
    logic             bad_c;
    logic [LW-1:0]    fbp_c;
    logic [BW-1:0]    b;
    logic [BW-1:0]    idx;
    logic [7:0]       value;

    assign exp_len  = LW'(10) + LW'({cnt_reg, 1'b0});
    assign end_addr = {1'b0, upper_reg, 16'h0000} + 33'(off_reg) + 33'(cnt_reg);
    assign words    = (33'(fwc_reg) > MAX_W) ? MAX_W : 33'(fwc_reg);

    always_comb
    begin
        el_err  = 1'b1;
        el_code = ERR_TYPE;
        el_eof  = 1'b0;
        el_base = 1'b0;
        if (!in_line_reg)
        begin
            el_err = 1'b0;
        end
        else if (len_reg >= LIM || len_reg < LW'(10) || len_reg[0])
        begin
            el_code = ERR_LENGTH;
        end
        else if (bad_reg && fbp_reg < LW'(8))
        begin
            el_code = ERR_DIGIT;
        end
        else if (len_reg != exp_len)
        begin
            el_code = ERR_COUNT;
        end
        else if (bad_reg)
        begin
            el_code = ERR_DIGIT;
        end
        else if (sum_reg != 8'd0)
        begin
            el_code = ERR_CHECKSUM;
        end
        else if (rkind_reg == REC_DATA)
        begin
            el_code = ERR_CAPACITY;
            el_err  = end_addr > {words[31:0], 1'b0};
        end
        else if (rkind_reg == REC_EOF)
        begin
            el_code = ERR_EOF_REC;
            el_err  = cnt_reg != 8'd0 || off_reg != 16'd0;
            el_eof  = !el_err;
        end
        else if (rkind_reg == REC_EXT)
        begin
            el_code = ERR_EXT_REC;
            el_err  = cnt_reg != 8'd2 || off_reg != 16'd0;
            el_base = !el_err;
        end
    end

    assign ws      = is_space(item.character);
    assign hd      = hex_decode(item.character);
    assign len_sum = {1'b0, len_reg} + {1'b0, psc_reg};
    assign b       = len_c[LW-1:1];
    assign idx     = b - BW'(4);
    assign value   = {hn_reg, hd[3:0]};

    always_comb
    begin
        bad_c = bad_reg;
        fbp_c = fbp_reg;
        len_c = len_reg;
        if (psc_reg != '0)
        begin
            if (len_reg < LIM && !bad_reg)
            begin
                bad_c = 1'b1;
                fbp_c = len_reg;
            end
            len_c = (len_sum > {1'b0, LIM}) ? LIM : len_sum[LW-1:0];
        end
    end

    always_comb
    begin
        eof_next     = eof_reg;
        upper_next   = upper_reg;
        halted_next  = halted_reg;
        in_line_next = in_line_reg;
        len_next     = len_reg;
        psc_next     = psc_reg;
        fbp_next     = fbp_reg;
        bad_next     = bad_reg;
        hn_next      = hn_reg;
        cnt_next     = cnt_reg;
        off_next     = off_reg;
        rkind_next   = rkind_reg;
        sum_next     = sum_reg;
        pb_next      = pb_reg;
        result       = '0;

        if (!halted_reg)
        begin
            if (item.action == ACT_END || item.character == CHAR_LF)
            begin
                in_line_next = 1'b0;
                len_next     = '0;
                psc_next     = '0;
                fbp_next     = '0;
                bad_next     = 1'b0;
                hn_next      = 4'd0;
                cnt_next     = 8'd0;
                off_next     = 16'd0;
                rkind_next   = 8'd0;
                sum_next     = 8'd0;
                pb_next      = 16'd0;
                if (!el_err && el_eof)
                begin
                    eof_next = 1'b1;
                end
                if (!el_err && el_base)
                begin
                    upper_next = pb_reg;
                end
                if (el_err)
                begin
                    halted_next       = 1'b1;
                    result.valid      = 1'b1;
                    result.kind       = KIND_ERROR;
                    result.error_code = el_code;
                end
                else if (item.action == ACT_END)
                begin
                    halted_next  = 1'b1;
                    result.valid = 1'b1;
                    if (eof_reg || el_eof)
                    begin
                        result.kind = KIND_DONE;
                    end
                    else
                    begin
                        result.kind       = KIND_ERROR;
                        result.error_code = ERR_NO_EOF;
                    end
                end
            end
            else if (!in_line_reg)
            begin
                if (!ws)
                begin
                    if (eof_reg || item.character != CHAR_COLON)
                    begin
                        halted_next       = 1'b1;
                        result.valid      = 1'b1;
                        result.kind       = KIND_ERROR;
                        result.error_code = eof_reg ? ERR_AFTER_EOF : ERR_NO_COLON;
                    end
                    else
                    begin
                        in_line_next = 1'b1;
                        len_next     = '0;
                        psc_next     = '0;
                        fbp_next     = '0;
                        bad_next     = 1'b0;
                        hn_next      = 4'd0;
                        cnt_next     = 8'd0;
                        off_next     = 16'd0;
                        rkind_next   = 8'd0;
                        sum_next     = 8'd0;
                        pb_next      = 16'd0;
                    end
                end
            end
            else if (ws)
            begin
                if (psc_reg < LIM)
                begin
                    psc_next = psc_reg + LW'(1);
                end
            end
            else
            begin
                psc_next = '0;
                len_next = len_c;
                bad_next = bad_c;
                fbp_next = fbp_c;
                if (len_c < LIM)
                begin
                    len_next = len_c + LW'(1);
                    if (!hd[4])
                    begin
                        if (!bad_c)
                        begin
                            bad_next = 1'b1;
                            fbp_next = len_c;
                        end
                    end
                    else if (!len_c[0])
                    begin
                        hn_next = hd[3:0];
                    end
                    else if (!bad_c)
                    begin
                        sum_next = sum_reg + value;
                        if (b == BW'(0))
                        begin
                            cnt_next = value;
                        end
                        else if (b == BW'(1))
                        begin
                            off_next = {value, off_reg[7:0]};
                        end
                        else if (b == BW'(2))
                        begin
                            off_next = {off_reg[15:8], value};
                        end
                        else if (b == BW'(3))
                        begin
                            rkind_next = value;
                        end
                        else if (idx < BW'(cnt_reg))
                        begin
                            if (b == BW'(4))
                            begin
                                pb_next = {value, pb_reg[7:0]};
                            end
                            if (b == BW'(5))
                            begin
                                pb_next = {pb_reg[15:8], value};
                            end
                            if (rkind_reg == REC_DATA)
                            begin
                                result.valid        = 1'b1;
                                result.kind         = KIND_WRITE;
                                result.data_byte    = value;
                                result.byte_address = {upper_reg[1:0], 16'h0000}
                                    + ADDR_W'(off_reg) + ADDR_W'(idx[7:0]);
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwc_reg <= FWC_RESET;
        end
        else if (cfg_wr_en)
        begin
            fwc_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eof_reg     <= 1'b0;
            upper_reg   <= 16'd0;
            halted_reg  <= 1'b0;
            in_line_reg <= 1'b0;
            len_reg     <= '0;
            psc_reg     <= '0;
            fbp_reg     <= '0;
            bad_reg     <= 1'b0;
            hn_reg      <= 4'd0;
            cnt_reg     <= 8'd0;
            off_reg     <= 16'd0;
            rkind_reg   <= 8'd0;
            sum_reg     <= 8'd0;
            pb_reg      <= 16'd0;
        end
        else if (fire)
        begin
            eof_reg     <= eof_next;
            upper_reg   <= upper_next;
            halted_reg  <= halted_next;
            in_line_reg <= in_line_next;
            len_reg     <= len_next;
            psc_reg     <= psc_next;
            fbp_reg     <= fbp_next;
            bad_reg     <= bad_next;
            hn_reg      <= hn_next;
            cnt_reg     <= cnt_next;
            off_reg     <= off_next;
            rkind_reg   <= rkind_next;
            sum_reg     <= sum_next;
            pb_reg      <= pb_next;
        end
    end

endmodule

>>> rtl/ihex_out_stage.sv
// ---------------------------------------------------------------------------
// ihex_out_stage
// result register holding one result until the sink takes it
// ---------------------------------------------------------------------------
module ihex_out_stage
    import ihex_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  ihex_result_t res_in,
    output logic         free,
    output logic         out_valid,
    input  logic         out_ready,
    output ihex_result_t res_out
);

    logic         valid_reg;
    ihex_result_t res_reg;

    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign res_out   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load && res_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load && res_in.valid)
        begin
            res_reg <= res_in;
        end
    end

endmodule

>>> rtl/intel_hex_record_decoder.sv
// ---------------------------------------------------------------------------
// intel_hex_record_decoder
// decodes intel hex text into flash byte writes and a final status
// ---------------------------------------------------------------------------
// channel     dir  tdata                              tuser
// s_axis      in   character[7:0]                     action
// m_axis      out  byte_address, data_byte, err_code  kind[1:0]
// cfg_wr      in   flash_word_count[17:0]             -
//
// one character per cycle while the result register is free; a result passes
// through the input register, one decode pass and the result register
// reset clears all line state, base, halt flag and capacity to 16384 words
// a stalled result holds the output; the input still takes one more item
// ---------------------------------------------------------------------------
module intel_hex_record_decoder
    import ihex_pkg::*;
#(
    parameter int LINE_LENGTH_LIMIT = IHEX_LINE_LENGTH_LIMIT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [FWC_W-1:0] cfg_wr_data,     // flash_word_count
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,    // character
    input  logic             s_axis_tuser,    // action
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [31:0]      m_axis_tdata,    // byte_address, data_byte, error_code
    output logic [1:0]       m_axis_tuser     // kind
);

    ihex_item_t   in_item;
    ihex_item_t   held_item;
    logic         held_valid;
    logic         out_free;
    logic         fire;
    ihex_result_t core_res;
    ihex_result_t out_res;

    assign in_item.action    = s_axis_tuser;
    assign in_item.character = s_axis_tdata;
    assign fire              = held_valid && out_free;

    ihex_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .take       (fire),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    ihex_core #(
        .LINE_LENGTH_LIMIT (LINE_LENGTH_LIMIT)
    ) u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (fire),
        .item        (held_item),
        .result      (core_res)
    );

    ihex_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .res_in    (core_res),
        .free      (out_free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .res_out   (out_res)
    );

    assign m_axis_tuser = out_res.kind;
    assign m_axis_tdata = {2'b00, out_res.error_code, out_res.data_byte, out_res.byte_address};

endmodule

>>> rtl/ihex_checker.sv
// ---------------------------------------------------------------------------
// ihex_checker
// port-level checks of the intel hex record decoder
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ihex_checker
    import ihex_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    logic out_xfer;
    logic final_xfer;

    assign out_xfer   = m_axis_tvalid && m_axis_tready;
    assign final_xfer = out_xfer && (m_axis_tuser != KIND_WRITE);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
    `ASSERT_NEXT(a_final_last, clk, rst_n, final_xfer, !m_axis_tvalid, "result after final status")
    `ASSERT_SAME(a_kind_known, clk, rst_n, m_axis_tvalid, m_axis_tuser == KIND_WRITE || m_axis_tuser == KIND_DONE || m_axis_tuser == KIND_ERROR, "bad kind")
    `ASSERT_SAME(a_write_code, clk, rst_n, m_axis_tvalid && m_axis_tuser == KIND_WRITE, m_axis_tdata[31:26] == 6'd0, "write carries error code")
    `ASSERT_SAME(a_status_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser != KIND_WRITE, m_axis_tdata[25:0] == 26'd0, "status carries address or data")

endmodule

bind intel_hex_record_decoder ihex_checker u_ihex_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// streams intel hex text into the record decoder and checks every flash write
// and the final status against a cycle-free decode of the same text; several
// capacity settings and idle patterns, then one randomly chosen image ending
// ----------------------------------------------------------------------------
module testbench;
    import ihex_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_MAX    = IHEX_LINE_LENGTH_LIMIT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 30;

    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_VT    = 8'd11;
    localparam logic [7:0] CHAR_FF    = 8'd12;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [FWC_W-1:0] cfg_wr_data = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata = 8'd0;
    logic             s_axis_tuser = ACT_CHAR;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [31:0]      m_axis_tdata;
    logic [1:0]       m_axis_tuser;

    intel_hex_record_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    ihex_item_t   hex_text[$];
    ihex_result_t decoded_results[$];
    logic [7:0]   rec_bytes[$];

    int unsigned queued_count = 0;
    int unsigned accepted_count = 0;
    int unsigned write_count = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    int          cap_bytes;
    logic [15:0] gen_base;
    logic [1:0]  last_kind = KIND_WRITE;
    logic [3:0]  last_code = ERR_AFTER_EOF;

    // decoder state as seen from the text stream
    logic [FWC_W-1:0] cap_words = FWC_RESET;
    bit               eof_done = 1'b0;
    bit               stopped = 1'b0;
    bit               in_line = 1'b0;
    bit               bad_seen = 1'b0;
    logic [15:0]      seg_base = 16'd0;
    logic [15:0]      rec_offset = 16'd0;
    logic [15:0]      ext_value = 16'd0;
    logic [7:0]       rec_count = 8'd0;
    logic [7:0]       rec_type = 8'd0;
    logic [7:0]       byte_sum = 8'd0;
    logic [3:0]       high_nib = 4'd0;
    int unsigned      line_len = 0;
    int unsigned      space_run = 0;
    int unsigned      bad_pos = 0;

    function automatic ihex_result_t make_result(input logic [1:0] k, input logic [17:0] a,
                                                 input logic [7:0] d, input logic [3:0] e);
        ihex_result_t r;
        r.valid        = 1'b1;
        r.kind         = k;
        r.byte_address = a;
        r.data_byte    = d;
        r.error_code   = e;
        return r;
    endfunction

    task automatic expect_result(input ihex_result_t r);
        decoded_results.insert(decoded_results.size(), r);
    endtask

    task automatic stage_byte(input logic [7:0] b);
        rec_bytes.insert(rec_bytes.size(), b);
    endtask

    function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] v);
        logic [7:0] t;
        if (c >= "0" && c <= "9")
            t = c - "0";
        else if (c >= "a" && c <= "f")
            t = c - "a" + 8'd10;
        else if (c >= "A" && c <= "F")
            t = c - "A" + 8'd10;
        else
        begin
            v = 4'd0;
            return 1'b0;
        end
        v = t[3:0];
        return 1'b1;
    endfunction

    task automatic reset_line();
        in_line    = 1'b0;
        line_len   = 0;
        space_run  = 0;
        bad_pos    = 0;
        bad_seen   = 1'b0;
        high_nib   = 4'd0;
        rec_count  = 8'd0;
        rec_offset = 16'd0;
        rec_type   = 8'd0;
        byte_sum   = 8'd0;
        ext_value  = 16'd0;
    endtask

    task automatic note_bad(input int unsigned pos);
        if (!bad_seen)
        begin
            bad_seen = 1'b1;
            bad_pos  = pos;
        end
    endtask

    task automatic decode_char(input logic [7:0] c);
        int unsigned pos;
        int unsigned idx;
        logic [3:0]  v;
        logic [7:0]  value;
        logic [31:0] full;
        // blanks followed by more text sit inside the line
        if (space_run != 0)
        begin
            if (line_len < LINE_MAX)
                note_bad(line_len);
            line_len += space_run;
            if (line_len > LINE_MAX)
                line_len = LINE_MAX;
            space_run = 0;
        end
        pos = line_len;
        if (pos >= LINE_MAX)
            return;
        line_len = pos + 1;
        if (!hex_digit(c, v))
        begin
            note_bad(pos);
            return;
        end
        if (pos % 2 == 0)
        begin
            high_nib = v;
            return;
        end
        if (bad_seen)
            return;
        value = {high_nib, v};
        byte_sum += value;
        idx = pos >> 1;
        if (idx == 0)
            rec_count = value;
        else if (idx == 1)
            rec_offset[15:8] = value;
        else if (idx == 2)
            rec_offset[7:0] = value;
        else if (idx == 3)
            rec_type = value;
        else if (idx - 4 < rec_count)
        begin
            if (idx == 4)
                ext_value[15:8] = value;
            if (idx == 5)
                ext_value[7:0] = value;
            if (rec_type == REC_DATA)
            begin
                full = {seg_base, 16'h0000} + rec_offset + (idx - 4);
                expect_result(make_result(KIND_WRITE, full[ADDR_W-1:0], value,
                                          ERR_AFTER_EOF));
            end
        end
    endtask

    task automatic close_line(output bit failed, output logic [3:0] code);
        longint unsigned words;
        longint unsigned top;
        failed = 1'b1;
        code   = ERR_AFTER_EOF;
        if (!in_line)
        begin
            failed = 1'b0;
            reset_line();
            return;
        end
        if (line_len >= LINE_MAX || line_len < 10 || line_len % 2 != 0)
            code = ERR_LENGTH;
        else if (bad_seen && bad_pos < 8)
            code = ERR_DIGIT;
        else if (line_len != 10 + 2 * rec_count)
            code = ERR_COUNT;
        else if (bad_seen)
            code = ERR_DIGIT;
        else if (byte_sum != 8'd0)
            code = ERR_CHECKSUM;
        else if (rec_type == REC_DATA)
        begin
            words = (cap_words > MAX_FLASH_WORDS) ? MAX_FLASH_WORDS : cap_words;
            top   = {seg_base, 16'h0000};
            top   = top + rec_offset + rec_count;
            if (top > 2 * words)
                code = ERR_CAPACITY;
            else
                failed = 1'b0;
        end
        else if (rec_type == REC_EOF)
        begin
            if (rec_count != 8'd0 || rec_offset != 16'd0)
                code = ERR_EOF_REC;
            else
            begin
                eof_done = 1'b1;
                failed   = 1'b0;
            end
        end
        else if (rec_type == REC_EXT)
        begin
            if (rec_count != 8'd2 || rec_offset != 16'd0)
                code = ERR_EXT_REC;
            else
            begin
                seg_base = ext_value;
                failed   = 1'b0;
            end
        end
        else
            code = ERR_TYPE;
        reset_line();
    endtask

    task automatic decode_transfer(input logic action, input logic [7:0] c);
        bit         failed;
        bit         ws;
        logic [3:0] code;
        if (stopped)
            return;
        if (action == ACT_END)
        begin
            close_line(failed, code);
            stopped = 1'b1;
            if (failed)
                expect_result(make_result(KIND_ERROR, '0, 8'd0, code));
            else if (!eof_done)
                expect_result(make_result(KIND_ERROR, '0, 8'd0, ERR_NO_EOF));
            else
                expect_result(make_result(KIND_DONE, '0, 8'd0, ERR_AFTER_EOF));
            return;
        end
        if (c == CHAR_LF)
        begin
            close_line(failed, code);
            if (failed)
            begin
                stopped = 1'b1;
                expect_result(make_result(KIND_ERROR, '0, 8'd0, code));
            end
            return;
        end
        ws = (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF || c == CHAR_CR);
        if (!in_line)
        begin
            if (ws)
                return;
            stopped = 1'b1;
            if (eof_done)
                expect_result(make_result(KIND_ERROR, '0, 8'd0, ERR_AFTER_EOF));
            else if (c != CHAR_COLON)
                expect_result(make_result(KIND_ERROR, '0, 8'd0, ERR_NO_COLON));
            else
            begin
                stopped = 1'b0;
                reset_line();
                in_line = 1'b1;
            end
            return;
        end
        if (ws)
        begin
            if (space_run < LINE_MAX)
                space_run++;
            return;
        end
        decode_char(c);
    endtask

    // text generation
    task automatic push_item(input logic action, input logic [7:0] c);
        ihex_item_t it;
        it.action    = action;
        it.character = c;
        hex_text.insert(hex_text.size(), it);
        queued_count++;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return "0" + n;
        if ($urandom_range(0, 1) == 0)
            return "a" + n - 8'd10;
        return "A" + n - 8'd10;
    endfunction

    task automatic push_byte(input logic [7:0] value);
        push_item(ACT_CHAR, hex_char(value[7:4]));
        push_item(ACT_CHAR, hex_char(value[3:0]));
    endtask

    task automatic push_string(input string s);
        foreach (s[i])
            push_item(ACT_CHAR, s[i]);
    endtask

    task automatic push_blanks(input bit trailing);
        int         n;
        logic [7:0] c;
        n = $urandom_range(0, 2);
        repeat (n)
        begin
            case ($urandom_range(0, trailing ? 4 : 1))
                0: c = CHAR_SPACE;
                1: c = CHAR_TAB;
                2: c = CHAR_CR;
                3: c = CHAR_VT;
                default: c = CHAR_FF;
            endcase
            push_item(ACT_CHAR, c);
        end
    endtask

    task automatic emit_record(input logic [7:0] rtype, input logic [15:0] offset,
                               input int count_adj, input logic [7:0] sum_adj,
                               input bit pad, input bit newline);
        logic [7:0] count;
        logic [7:0] sum;
        count = 8'(rec_bytes.size() + count_adj);
        if (pad)
            push_blanks(1'b0);
        push_item(ACT_CHAR, CHAR_COLON);
        sum = count + offset[15:8] + offset[7:0] + rtype;
        push_byte(count);
        push_byte(offset[15:8]);
        push_byte(offset[7:0]);
        push_byte(rtype);
        foreach (rec_bytes[i])
        begin
            push_byte(rec_bytes[i]);
            sum += rec_bytes[i];
        end
        push_byte(8'd0 - sum + sum_adj);
        if (pad)
            push_blanks(1'b1);
        if (newline)
            push_item(ACT_CHAR, CHAR_LF);
        rec_bytes.delete();
    endtask

    task automatic ext_record(input logic [15:0] base);
        stage_byte(base[15:8]);
        stage_byte(base[7:0]);
        emit_record(REC_EXT, 16'h0000, 0, 8'd0, 1'b1, 1'b1);
        gen_base = base;
    endtask

    task automatic random_ext_record();
        if (cap_bytes > 0)
            ext_record(16'($urandom_range(0, (cap_bytes - 1) / 65536)));
        else
            ext_record(16'h0000);
    endtask

    task automatic data_record(input int count, input int offset);
        repeat (count)
        begin
            case ($urandom_range(0, 7))
                0: stage_byte(8'h00);
                1: stage_byte(8'hFF);
                default: stage_byte(8'($urandom_range(0, 255)));
            endcase
        end
        emit_record(REC_DATA, 16'(offset), 0, 8'd0, 1'b1, 1'b1);
    endtask

    task automatic random_data_record();
        int room;
        int maxc;
        int count;
        int omax;
        int offset;
        room = cap_bytes - int'(gen_base) * 65536;
        if (room < 0)
            room = 0;
        maxc = (room < 16) ? room : 16;
        if ($urandom_range(0, 9) == 0)
            maxc = (room < 64) ? room : 64;
        count = $urandom_range(0, maxc);
        omax = room - count;
        if (omax > 65535)
            omax = 65535;
        case ($urandom_range(0, 3))
            0: offset = 0;
            1: offset = omax;
            default: offset = $urandom_range(0, omax);
        endcase
        data_record(count, offset);
    endtask

    task automatic blank_line();
        push_blanks(1'b1);
        push_item(ACT_CHAR, CHAR_LF);
    endtask

    task automatic drain(input int settle);
        while (accepted_count != queued_count || decoded_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [FWC_W-1:0] words);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= words;
        cap_words = words;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 59; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 59; end
            default: begin sender_idle_pct = 37; receiver_stall_pct = 37; end
        endcase
    endtask

    task automatic finish_image();
        ihex_item_t it;
        logic [7:0] c;
        logic [7:0] t;
        case ($urandom_range(0, 13))
            0: emit_record(REC_EOF, 16'h0000, 0, 8'd0, 1'b1, 1'b1);
            1: emit_record(REC_EOF, 16'h0000, 0, 8'd0, 1'b1, 1'b0);
            2: random_data_record();
            3:
            begin
                emit_record(REC_EOF, 16'h0000, 0, 8'd0, 1'b1, 1'b1);
                blank_line();
                push_string(":00000001FF");
                push_item(ACT_CHAR, CHAR_LF);
            end
            4:
            begin
                c = 8'($urandom_range(33, 255));
                if (c == CHAR_COLON)
                    c = 8'hFF;
                push_blanks(1'b0);
                push_item(ACT_CHAR, c);
            end
            5:
            begin
                push_string(":00000001");
                push_item(ACT_CHAR, CHAR_LF);
            end
            6:
            begin
                push_string(":01G00000AAFF");
                push_item(ACT_CHAR, CHAR_LF);
            end
            7:
            begin
                stage_byte(8'h11);
                stage_byte(8'h22);
                emit_record(REC_DATA, 16'h0000, 0, 8'd0, 1'b0, 1'b1);
                it = hex_text[hex_text.size() - 4];
                it.character = "z";
                hex_text[hex_text.size() - 4] = it;
            end
            8:
            begin
                repeat (3) stage_byte(8'($urandom_range(0, 255)));
                emit_record(REC_DATA, 16'h0000, -1, 8'd0, 1'b1, 1'b1);
            end
            9:
            begin
                stage_byte(8'($urandom_range(0, 255)));
                emit_record(REC_DATA, 16'h0000, 0, 8'($urandom_range(1, 255)), 1'b1, 1'b1);
            end
            10:
            begin
                // runs past the top of any capacity and wraps the reported address
                ext_record(16'h0003);
                repeat (32) stage_byte(8'($urandom_range(0, 255)));
                emit_record(REC_DATA, 16'hFFF0, 0, 8'd0, 1'b1, 1'b1);
            end
            11:
            begin
                stage_byte(8'h00);
                emit_record(REC_EOF, 16'h0000, 0, 8'd0, 1'b1, 1'b1);
            end
            12:
            begin
                stage_byte(8'h01);
                emit_record(REC_EXT, 16'h0000, 0, 8'd0, 1'b1, 1'b1);
            end
            default:
            begin
                t = 8'($urandom_range(2, 255));
                if (t == REC_EXT)
                    t = 8'h05;
                stage_byte(8'($urandom_range(0, 255)));
                emit_record(t, 16'h0000, 0, 8'd0, 1'b1, 1'b1);
            end
        endcase
        push_item(ACT_END, 8'($urandom_range(0, 255)));
        // ignored once the block has stopped
        push_item(ACT_CHAR, 8'hFF);
        push_item(ACT_END, 8'h80);
        repeat (20) push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endtask

    // stimulus
    initial
    begin
        logic [FWC_W-1:0] word_settings[PHASES];
        int unsigned      start;
        int               r;
        word_settings = '{FWC_RESET, 18'd131072, 18'd0, 18'h3FFFF,
                          18'($urandom_range(1, 131071)), 18'd1};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_idling(ph);
            if (ph != 0)
                write_capacity(word_settings[ph]);
            cap_bytes = 2 * ((cap_words > MAX_FLASH_WORDS) ? MAX_FLASH_WORDS
                                                           : int'(cap_words));
            start = queued_count;
            if (ph == 0)
            begin
                blank_line();
                ext_record(16'h0000);
                data_record(0, 0);
                stage_byte(8'hFF);
                emit_record(REC_DATA, 16'(cap_bytes - 1), 0, 8'd0, 1'b0, 1'b1);
                data_record(2, 0);
                data_record(255, 256);
            end
            random_ext_record();
            while (queued_count - start < PHASE_ITEMS)
            begin
                r = $urandom_range(0, 19);
                if (r < 2)
                    blank_line();
                else if (r < 4)
                    random_ext_record();
                else
                    random_data_record();
            end
            drain(4);
        end
        set_idling(3);
        finish_image();
        drain(12);
        $display("%0d transfers in, %0d flash writes checked over %0d capacity settings",
                 accepted_count, write_count, PHASES);
        $display("image closed with kind %0d, code %0d", last_kind, last_code);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // input driver
    ihex_item_t next_item;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_transfer(s_axis_tuser, s_axis_tdata);
                accepted_count++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (hex_text.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    next_item = hex_text.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_item.character;
                    s_axis_tuser  <= next_item.action;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);

    // result monitor
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endtask

    ihex_result_t want_result;

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            last_kind = m_axis_tuser;
            last_code = m_axis_tdata[29:26];
            if (m_axis_tuser == KIND_WRITE)
                write_count++;
            if (decoded_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual kind %0d tdata 0x%h",
                         $time, m_axis_tuser, m_axis_tdata);
            end
            else
            begin
                want_result = decoded_results.pop_front();
                check_field("kind", want_result.kind, m_axis_tuser);
                check_field("byte_address", want_result.byte_address, m_axis_tdata[17:0]);
                check_field("data_byte", want_result.data_byte, m_axis_tdata[25:18]);
                check_field("error_code", want_result.error_code, m_axis_tdata[29:26]);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, decoded_results.size());
            $display("Verification failed");
            $finish;
        end
    end

endmodule
